@@ hw/rtl/stq_pkg.sv @@
// Shared types, constants and helpers for the segment to quad expander.
package stq_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned WidthW   = 16;
  localparam int unsigned NumW     = 49;   // 2*width*magnitude plus rounding term
  localparam int unsigned QuotW    = 19;   // offset magnitude
  localparam int unsigned RootW    = 32;
  localparam int unsigned SqW      = 64;
  localparam int unsigned GreenScale = 100;
  localparam int unsigned OneQ88     = 256;
  localparam int unsigned GreenMax   = 255;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_z;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] end_z;
    logic        [WidthW-1:0] line_width;
  } seg_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] corner0_x;
    logic signed [CoordW-1:0] corner0_y;
    logic signed [CoordW-1:0] corner1_x;
    logic signed [CoordW-1:0] corner1_y;
    logic signed [CoordW-1:0] corner2_x;
    logic signed [CoordW-1:0] corner2_y;
    logic signed [CoordW-1:0] corner3_x;
    logic signed [CoordW-1:0] corner3_y;
    logic signed [CoordW-1:0] height_start;
    logic signed [CoordW-1:0] height_end;
    logic        [7:0]        green_level;
    logic                     degenerate;
  } quad_out_t;

  // Per-segment data that rides alongside the arithmetic.
  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
    logic signed [CoordW-1:0] qx;
    logic signed [CoordW-1:0] qy;
    logic signed [CoordW-1:0] qz;
    logic        [7:0]        green;
    logic                     degen;
    logic                     neg_x;
    logic                     neg_y;
  } meta_t;

  typedef struct packed {
    meta_t           meta;
    logic [NumW-1:0] num_a;
    logic [NumW-1:0] num_b;
  } sqrt_side_t;

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [CoordW+1:0] v);
    logic signed [CoordW+1:0] hi;
    logic signed [CoordW+1:0] lo;
    hi = $signed({3'b000, {(CoordW-1){1'b1}}});
    lo = $signed({3'b111, {(CoordW-1){1'b0}}});
    if (v > hi) begin
      return hi[CoordW-1:0];
    end else if (v < lo) begin
      return lo[CoordW-1:0];
    end
    return v[CoordW-1:0];
  endfunction

endpackage

@@ hw/rtl/stq_sqrt_pipe.sv @@
// Pipelined integer square root, one result bit per stage, with sideband.
module stq_sqrt_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [stq_pkg::SqW-1:0]       sq_i,
  input  stq_pkg::sqrt_side_t           side_i,
  output logic                          valid_o,
  output logic [stq_pkg::RootW-1:0]     root_o,
  output stq_pkg::sqrt_side_t           side_o
);

  localparam int unsigned N  = stq_pkg::RootW;
  localparam int unsigned RW = stq_pkg::SqW;
  localparam int unsigned TW = RW + 2;

  logic                 valid_q [N];
  logic [RW-1:0]        rem_q   [N];
  logic [N-1:0]         root_q  [N];
  stq_pkg::sqrt_side_t  side_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int unsigned Bit = N - 1 - k;
    logic                valid_c;
    logic [RW-1:0]       rem_c;
    logic [N-1:0]        root_c;
    stq_pkg::sqrt_side_t side_c;
    logic [TW-1:0]       trial;
    logic [RW-1:0]       rem_d;
    logic [N-1:0]        root_d;

    if (k == 0) begin : g_first
      assign valid_c = valid_i;
      assign rem_c   = sq_i;
      assign root_c  = '0;
      assign side_c  = side_i;
    end else begin : g_rest
      assign valid_c = valid_q[k-1];
      assign rem_c   = rem_q[k-1];
      assign root_c  = root_q[k-1];
      assign side_c  = side_q[k-1];
    end

    // (root + 2^i)^2 - root^2 = root*2^(i+1) + 2^(2i)
    assign trial = ({{(TW-N){1'b0}}, root_c} << (Bit + 1)) + ({{(TW-1){1'b0}}, 1'b1} << (2 * Bit));

    always_comb begin
      rem_d  = rem_c;
      root_d = root_c;
      if ({2'b00, rem_c} >= trial) begin
        rem_d  = rem_c - trial[RW-1:0];
        root_d = root_c | ({{(N-1){1'b0}}, 1'b1} << Bit);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        side_q[k] <= side_c;
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

@@ hw/rtl/stq_div_pipe.sv @@
// Pipelined restoring divider, two numerators over one divisor, one bit per stage.
module stq_div_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [stq_pkg::RootW-1:0]     len_i,
  input  logic [stq_pkg::NumW-1:0]      num_a_i,
  input  logic [stq_pkg::NumW-1:0]      num_b_i,
  input  stq_pkg::meta_t                meta_i,
  output logic                          valid_o,
  output logic [stq_pkg::QuotW-1:0]     quot_a_o,
  output logic [stq_pkg::QuotW-1:0]     quot_b_o,
  output stq_pkg::meta_t                meta_o
);

  localparam int unsigned N  = stq_pkg::QuotW;
  localparam int unsigned NW = stq_pkg::NumW;
  localparam int unsigned LW = stq_pkg::RootW;
  localparam int unsigned TW = NW + 2;

  logic            valid_q [N];
  logic [LW-1:0]   len_q   [N];
  logic [NW-1:0]   rem_a_q [N];
  logic [NW-1:0]   rem_b_q [N];
  logic [N-1:0]    quo_a_q [N];
  logic [N-1:0]    quo_b_q [N];
  stq_pkg::meta_t  meta_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int unsigned Bit = N - 1 - k;
    logic           valid_c;
    logic [LW-1:0]  len_c;
    logic [NW-1:0]  rem_a_c;
    logic [NW-1:0]  rem_b_c;
    logic [N-1:0]   quo_a_c;
    logic [N-1:0]   quo_b_c;
    stq_pkg::meta_t meta_c;
    logic [TW-1:0]  trial;
    logic [NW-1:0]  rem_a_d;
    logic [NW-1:0]  rem_b_d;
    logic [N-1:0]   quo_a_d;
    logic [N-1:0]   quo_b_d;

    if (k == 0) begin : g_first
      assign valid_c = valid_i;
      assign len_c   = len_i;
      assign rem_a_c = num_a_i;
      assign rem_b_c = num_b_i;
      assign quo_a_c = '0;
      assign quo_b_c = '0;
      assign meta_c  = meta_i;
    end else begin : g_rest
      assign valid_c = valid_q[k-1];
      assign len_c   = len_q[k-1];
      assign rem_a_c = rem_a_q[k-1];
      assign rem_b_c = rem_b_q[k-1];
      assign quo_a_c = quo_a_q[k-1];
      assign quo_b_c = quo_b_q[k-1];
      assign meta_c  = meta_q[k-1];
    end

    assign trial = {{(TW-LW){1'b0}}, len_c} << Bit;

    always_comb begin
      rem_a_d = rem_a_c;
      rem_b_d = rem_b_c;
      quo_a_d = quo_a_c;
      quo_b_d = quo_b_c;
      if ({2'b00, rem_a_c} >= trial) begin
        rem_a_d = rem_a_c - trial[NW-1:0];
        quo_a_d = quo_a_c | ({{(N-1){1'b0}}, 1'b1} << Bit);
      end
      if ({2'b00, rem_b_c} >= trial) begin
        rem_b_d = rem_b_c - trial[NW-1:0];
        quo_b_d = quo_b_c | ({{(N-1){1'b0}}, 1'b1} << Bit);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        len_q[k]   <= len_c;
        rem_a_q[k] <= rem_a_d;
        rem_b_q[k] <= rem_b_d;
        quo_a_q[k] <= quo_a_d;
        quo_b_q[k] <= quo_b_d;
        meta_q[k]  <= meta_c;
      end
    end
  end

  assign valid_o  = valid_q[N-1];
  assign quot_a_o = quo_a_q[N-1];
  assign quot_b_o = quo_b_q[N-1];
  assign meta_o   = meta_q[N-1];

endmodule

@@ hw/rtl/segment_to_quad_expander.sv @@
// Top level: expands a line segment with a width into four quad corners.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_ready_o   stq_pkg::seg_in_t
//   out      output     out_valid_o / out_ready_i stq_pkg::quad_out_t
//
// One segment enters per cycle unless the output stalls; each result passes through 6
// front stages (difference, magnitude, two normalize steps, squares, sum), 32 square
// root stages (one root bit each), 1 rounding stage, 19 divider stages and the
// output register. Reset clears only the valid bits. A stall at the output
// freezes the whole pipeline in place, so in_ready_o follows out_ready_i
// whenever the output register holds a result.
module segment_to_quad_expander (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  stq_pkg::seg_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stq_pkg::quad_out_t out_data_o
);

  localparam int unsigned CW = stq_pkg::CoordW;
  localparam int unsigned WW = stq_pkg::WidthW;
  localparam int unsigned NW = stq_pkg::NumW;
  localparam int unsigned QW = stq_pkg::QuotW;
  localparam int unsigned LW = stq_pkg::RootW;
  localparam int unsigned SW = stq_pkg::SqW;
  localparam int unsigned GW = 24;
  localparam logic [GW-1:0] GreenBias = GW'(stq_pkg::GreenScale * stq_pkg::OneQ88);

  logic en;
  logic out_valid_q;
  stq_pkg::quad_out_t out_q, out_d;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: normal vector and color level.
  logic                   s1_valid_q;
  stq_pkg::meta_t         s1_meta_q, s1_meta_d;
  logic signed [CW:0]     s1_nx_q, s1_ny_q;
  logic [WW-1:0]          s1_w_q;
  logic [GW-1:0]          green_raw;
  logic [GW-1:0]          green_off;

  always_comb begin
    green_raw = GW'(in_data_i.line_width) * GW'(stq_pkg::GreenScale);
    green_off = green_raw - GreenBias;
    s1_meta_d       = '0;
    s1_meta_d.px    = in_data_i.start_x;
    s1_meta_d.py    = in_data_i.start_y;
    s1_meta_d.pz    = in_data_i.start_z;
    s1_meta_d.qx    = in_data_i.end_x;
    s1_meta_d.qy    = in_data_i.end_y;
    s1_meta_d.qz    = in_data_i.end_z;
    if (green_raw < GreenBias) begin
      s1_meta_d.green = '0;
    end else if (green_off[GW-1:8] > (GW-8)'(stq_pkg::GreenMax)) begin
      s1_meta_d.green = 8'(stq_pkg::GreenMax);
    end else begin
      s1_meta_d.green = green_off[15:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_meta_q <= s1_meta_d;
      s1_nx_q   <= {in_data_i.end_y[CW-1], in_data_i.end_y}
                 - {in_data_i.start_y[CW-1], in_data_i.start_y};
      s1_ny_q   <= {in_data_i.start_x[CW-1], in_data_i.start_x}
                 - {in_data_i.end_x[CW-1], in_data_i.end_x};
      s1_w_q    <= in_data_i.line_width;
    end
  end

  // Stage 2: magnitudes, signs, degenerate flag.
  logic            s2_valid_q;
  stq_pkg::meta_t  s2_meta_q, s2_meta_d;
  logic [CW:0]     s2_a_q, s2_b_q;
  logic [WW-1:0]   s2_w_q;

  always_comb begin
    s2_meta_d       = s1_meta_q;
    s2_meta_d.neg_x = s1_nx_q[CW];
    s2_meta_d.neg_y = s1_ny_q[CW];
    s2_meta_d.degen = (s1_nx_q == '0) && (s1_ny_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_meta_q <= s2_meta_d;
      s2_a_q    <= s1_nx_q[CW] ? -s1_nx_q : s1_nx_q;
      s2_b_q    <= s1_ny_q[CW] ? -s1_ny_q : s1_ny_q;
      s2_w_q    <= s1_w_q;
    end
  end

  // Stage 3: halve a too-large pair, otherwise coarse left shifts by 16 and 8.
  logic            s3_valid_q;
  stq_pkg::meta_t  s3_meta_q;
  logic [CW-1:0]   s3_a_q, s3_b_q, s3_o_q;
  logic [CW-1:0]   s3_a_d, s3_b_d, s3_o_d;
  logic [WW-1:0]   s3_w_q;
  logic [CW:0]     s2_or;

  always_comb begin
    s2_or = s2_a_q | s2_b_q;
    if (s2_or[CW] || s2_or[CW-1]) begin
      s3_a_d = s2_a_q[CW:1];
      s3_b_d = s2_b_q[CW:1];
      s3_o_d = s2_or[CW:1];
    end else begin
      s3_a_d = s2_a_q[CW-1:0];
      s3_b_d = s2_b_q[CW-1:0];
      s3_o_d = s2_or[CW-1:0];
    end
    if (s3_o_d[CW-1:15] == '0) begin
      s3_a_d = s3_a_d << 16;
      s3_b_d = s3_b_d << 16;
      s3_o_d = s3_o_d << 16;
    end
    if (s3_o_d[CW-1:23] == '0) begin
      s3_a_d = s3_a_d << 8;
      s3_b_d = s3_b_d << 8;
      s3_o_d = s3_o_d << 8;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_meta_q <= s2_meta_q;
      s3_a_q    <= s3_a_d;
      s3_b_q    <= s3_b_d;
      s3_o_q    <= s3_o_d;
      s3_w_q    <= s2_w_q;
    end
  end

  // Stage 4: fine left shifts by 4, 2 and 1 until bit 30 or bit 31 is set.
  logic            s4_valid_q;
  stq_pkg::meta_t  s4_meta_q;
  logic [CW-1:0]   s4_a_q, s4_b_q;
  logic [CW-1:0]   s4_a_d, s4_b_d, s4_o_d;
  logic [WW-1:0]   s4_w_q;

  always_comb begin
    s4_a_d = s3_a_q;
    s4_b_d = s3_b_q;
    s4_o_d = s3_o_q;
    if (s4_o_d[CW-1:27] == '0) begin
      s4_a_d = s4_a_d << 4;
      s4_b_d = s4_b_d << 4;
      s4_o_d = s4_o_d << 4;
    end
    if (s4_o_d[CW-1:29] == '0) begin
      s4_a_d = s4_a_d << 2;
      s4_b_d = s4_b_d << 2;
      s4_o_d = s4_o_d << 2;
    end
    if (s4_o_d[CW-1:30] == '0) begin
      s4_a_d = s4_a_d << 1;
      s4_b_d = s4_b_d << 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_meta_q <= s3_meta_q;
      s4_a_q    <= s4_a_d;
      s4_b_q    <= s4_b_d;
      s4_w_q    <= s3_w_q;
    end
  end

  // Stage 5: squares and scaled numerators.
  logic            s5_valid_q;
  stq_pkg::meta_t  s5_meta_q;
  logic [SW-1:0]   s5_sqa_q, s5_sqb_q;
  logic [NW-1:0]   s5_na_q, s5_nb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_meta_q <= s4_meta_q;
      s5_sqa_q  <= SW'(s4_a_q) * SW'(s4_a_q);
      s5_sqb_q  <= SW'(s4_b_q) * SW'(s4_b_q);
      s5_na_q   <= NW'({s4_w_q, 1'b0}) * NW'(s4_a_q);
      s5_nb_q   <= NW'({s4_w_q, 1'b0}) * NW'(s4_b_q);
    end
  end

  // Stage 6: sum of squares.
  logic                 s6_valid_q;
  logic [SW-1:0]        s6_sum_q;
  stq_pkg::sqrt_side_t  s6_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_sum_q        <= s5_sqa_q + s5_sqb_q;
      s6_side_q.meta  <= s5_meta_q;
      s6_side_q.num_a <= s5_na_q;
      s6_side_q.num_b <= s5_nb_q;
    end
  end

  logic                sq_valid;
  logic [LW-1:0]       sq_root;
  stq_pkg::sqrt_side_t sq_side;

  stq_sqrt_pipe u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s6_valid_q),
    .sq_i    (s6_sum_q),
    .side_i  (s6_side_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Stage 7: guard zero length, add half the divisor for rounding.
  logic            s7_valid_q;
  logic [LW-1:0]   s7_len_q, s7_len_d;
  logic [NW-1:0]   s7_na_q, s7_nb_q;
  stq_pkg::meta_t  s7_meta_q;

  assign s7_len_d = (sq_root == '0) ? LW'(1) : sq_root;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_len_q  <= s7_len_d;
      s7_na_q   <= sq_side.num_a + NW'(s7_len_d >> 1);
      s7_nb_q   <= sq_side.num_b + NW'(s7_len_d >> 1);
      s7_meta_q <= sq_side.meta;
    end
  end

  logic            dv_valid;
  logic [QW-1:0]   dv_qa, dv_qb;
  stq_pkg::meta_t  dv_meta;

  stq_div_pipe u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s7_valid_q),
    .len_i    (s7_len_q),
    .num_a_i  (s7_na_q),
    .num_b_i  (s7_nb_q),
    .meta_i   (s7_meta_q),
    .valid_o  (dv_valid),
    .quot_a_o (dv_qa),
    .quot_b_o (dv_qb),
    .meta_o   (dv_meta)
  );

  // Output stage: signed offsets, corners, saturation.
  logic signed [CW+1:0] off_x, off_y;
  logic signed [CW+1:0] px_e, py_e, qx_e, qy_e;

  always_comb begin
    off_x = $signed({{(CW+2-QW){1'b0}}, dv_qa});
    off_y = $signed({{(CW+2-QW){1'b0}}, dv_qb});
    if (dv_meta.degen) begin
      off_x = '0;
      off_y = '0;
    end
    if (dv_meta.neg_x) begin
      off_x = -off_x;
    end
    if (dv_meta.neg_y) begin
      off_y = -off_y;
    end
    px_e = {{2{dv_meta.px[CW-1]}}, dv_meta.px};
    py_e = {{2{dv_meta.py[CW-1]}}, dv_meta.py};
    qx_e = {{2{dv_meta.qx[CW-1]}}, dv_meta.qx};
    qy_e = {{2{dv_meta.qy[CW-1]}}, dv_meta.qy};
    out_d.corner0_x    = stq_pkg::sat32(px_e - off_x);
    out_d.corner0_y    = stq_pkg::sat32(py_e - off_y);
    out_d.corner1_x    = stq_pkg::sat32(px_e + off_x);
    out_d.corner1_y    = stq_pkg::sat32(py_e + off_y);
    out_d.corner2_x    = stq_pkg::sat32(qx_e - off_x);
    out_d.corner2_y    = stq_pkg::sat32(qy_e - off_y);
    out_d.corner3_x    = stq_pkg::sat32(qx_e + off_x);
    out_d.corner3_y    = stq_pkg::sat32(qy_e + off_y);
    out_d.height_start = dv_meta.pz;
    out_d.height_end   = dv_meta.qz;
    out_d.green_level  = dv_meta.green;
    out_d.degenerate   = dv_meta.degen;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  // Valid bits of the front stages, the rounding stage and the output register; hold on stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      s6_valid_q  <= 1'b0;
      s7_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      s6_valid_q  <= s5_valid_q;
      s7_valid_q  <= sq_valid;
      out_valid_q <= dv_valid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/stq_checker.sv @@
// Port-level checks for the segment to quad expander, bound to the top level.
module stq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input stq_pkg::seg_in_t   in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input stq_pkg::quad_out_t out_data_o
);

  // A pending result holds until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // Input backpressure only comes from a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // A degenerate segment has zero offset: paired corners coincide.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.corner0_x == out_data_o.corner1_x &&
      out_data_o.corner0_y == out_data_o.corner1_y &&
      out_data_o.corner2_x == out_data_o.corner3_x &&
      out_data_o.corner2_y == out_data_o.corner3_y)
    else $error("degenerate result with nonzero offset");

  // No result is shown directly after reset is seen asserted.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind segment_to_quad_expander stq_checker u_stq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ tb/tb_top.sv @@
// Testbench for segment_to_quad_expander: random and directed segments checked against a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  class quad_scoreboard;
    stq_pkg::quad_out_t pending[$];
    int mismatches;
    int checked;
    int degen_seen;
    int sat_seen;

    function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function automatic longint unsigned int_root(longint unsigned s);
      longint unsigned rem, root, bitv;
      rem = s;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    function automatic stq_pkg::quad_out_t expand(stq_pkg::seg_in_t s);
      stq_pkg::quad_out_t q;
      longint px, py, qx, qy, nx, ny, offx, offy, g, w;
      longint unsigned a, b, m, len, ma, mb;
      px = longint'(s.start_x);
      py = longint'(s.start_y);
      qx = longint'(s.end_x);
      qy = longint'(s.end_y);
      w = longint'({48'd0, s.line_width});
      nx = qy - py;
      ny = px - qx;
      offx = 0;
      offy = 0;
      q.degenerate = (nx == 0 && ny == 0);
      if (!q.degenerate) begin
        a = (nx < 0) ? -nx : nx;
        b = (ny < 0) ? -ny : ny;
        m = (a > b) ? a : b;
        if (m >= 64'h80000000) begin
          a >>= 1;
          b >>= 1;
        end else begin
          while (m < 64'h40000000) begin
            m <<= 1;
            a <<= 1;
            b <<= 1;
          end
        end
        len = int_root(a * a + b * b);
        if (len == 0) len = 1;
        ma = (2 * w * a + (len >> 1)) / len;
        mb = (2 * w * b + (len >> 1)) / len;
        offx = (nx < 0) ? -longint'(ma) : longint'(ma);
        offy = (ny < 0) ? -longint'(mb) : longint'(mb);
      end
      g = 100 * w - 25600;
      if (g < 0) g = 0;
      else g = g / 256;
      if (g > 255) g = 255;
      q.corner0_x = clamp32(px - offx);
      q.corner0_y = clamp32(py - offy);
      q.corner1_x = clamp32(px + offx);
      q.corner1_y = clamp32(py + offy);
      q.corner2_x = clamp32(qx - offx);
      q.corner2_y = clamp32(qy - offy);
      q.corner3_x = clamp32(qx + offx);
      q.corner3_y = clamp32(qy + offy);
      q.height_start = s.start_z;
      q.height_end = s.end_z;
      q.green_level = g[7:0];
      if (q.degenerate) degen_seen++;
      if (px + offx > 64'sd2147483647 || px - offx < -64'sd2147483648 ||
          qx + offx > 64'sd2147483647 || qx - offx < -64'sd2147483648 ||
          py + offy > 64'sd2147483647 || py - offy < -64'sd2147483648 ||
          qy + offy > 64'sd2147483647 || qy - offy < -64'sd2147483648) sat_seen++;
      return q;
    endfunction

    function void note_segment(stq_pkg::seg_in_t s);
      pending.push_back(expand(s));
    endfunction

    function void check_quad(stq_pkg::quad_out_t got);
      stq_pkg::quad_out_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected quad %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("quad mismatch: expected %h got %h", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  stq_pkg::seg_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  stq_pkg::quad_out_t out_data;

  quad_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  bit timed_out = 0;

  segment_to_quad_expander dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .in_data_i(in_data), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_data_o(out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_segment(in_data);
      if (out_valid && out_ready) sb.check_quad(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (!in_valid && sb.pending.size() == 0)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles > 20000 && !timed_out) begin
      timed_out = 1;
      $display("segment_to_quad_expander verification failed");
      $finish;
    end
  end

  // Drop valid only while idling, so back-to-back requests keep it high.
  task automatic send_segment(stq_pkg::seg_in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7fffffff - $urandom_range(3);
      1: return 32'h80000000 + $urandom_range(3);
      2: return $urandom_range(2000) - 1000;
      default: return $urandom();
    endcase
  endfunction

  function automatic stq_pkg::seg_in_t rand_segment();
    stq_pkg::seg_in_t s;
    s.start_x = rand_coord();
    s.start_y = rand_coord();
    s.start_z = $urandom();
    s.line_width = ($urandom_range(3) == 0) ? 16'($urandom_range(600)) : 16'($urandom());
    case ($urandom_range(7))
      0: begin
        s.end_x = s.start_x;
        s.end_y = s.start_y;
      end
      1: begin
        s.end_x = s.start_x + $urandom_range(4) - 2;
        s.end_y = s.start_y;
      end
      2: begin
        s.end_x = s.start_x;
        s.end_y = s.start_y + $urandom_range(4) - 2;
      end
      3: begin
        s.end_x = s.start_x + $urandom_range(200) - 100;
        s.end_y = s.start_y + $urandom_range(200) - 100;
      end
      default: begin
        s.end_x = rand_coord();
        s.end_y = rand_coord();
      end
    endcase
    s.end_z = $urandom();
    return s;
  endfunction

  task automatic directed_segments();
    stq_pkg::seg_in_t s;
    logic [31:0] xs[4] = '{32'h80000000, 32'h7fffffff, 32'h0, 32'hffffff00};
    for (int i = 0; i < 4; i++) begin
      s = '0;
      s.start_x = xs[i];
      s.start_y = xs[3 - i];
      s.end_x = xs[3 - i];
      s.end_y = xs[i];
      s.start_z = xs[i];
      s.end_z = xs[3 - i];
      s.line_width = (i == 0) ? 16'hffff : (i == 1) ? 16'h0 : (i == 2) ? 16'h0100 : 16'h01ff;
      send_segment(s);
    end
    s = '0;
    s.line_width = 16'h0300;
    send_segment(s);            // coincident endpoints
    s.start_x = 32'h7fffff00;
    s.end_x = 32'h7fffff00;
    s.end_y = 32'h00000100;
    s.line_width = 16'hffff;    // saturating corners
    send_segment(s);
    s.start_x = 32'h80000000;
    s.end_x = 32'h80000000;
    send_segment(s);
    s = '0;
    s.end_x = 32'h1;
    s.line_width = 16'h00ff;
    send_segment(s);
    s.end_x = 32'h0;
    s.end_y = 32'hffffffff;
    s.line_width = 16'h0101;
    send_segment(s);
    s.end_x = 32'h3;
    s.end_y = 32'h4;
    s.line_width = 16'h8000;
    send_segment(s);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int idle_set[4] = '{0, 53, 0, 17};
    int stall_set[4] = '{0, 0, 53, 17};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_segments();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      for (int i = 0; i < 350; i++) begin
        send_segment(rand_segment());
        if (ph == 1 && i == 100) drain();   // hold until all quads have returned
      end
    end
    recv_stall_pct = 0;
    drain();
    repeat (80) @(posedge clk);
    $display("checked %0d quads: %0d coincident segments, %0d with saturated corners",
             sb.checked, sb.degen_seen, sb.sat_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("segment_to_quad_expander verification clean");
    else
      $display("segment_to_quad_expander verification failed");
    $finish;
  end
endmodule
